// ===== src/pmt_pkg.sv =====
package pmt_pkg;

  localparam int unsigned Depth = 1024;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned PosW = 11;
  localparam int unsigned ValW = 30;
  localparam int unsigned StatW = 2;

  localparam logic [ValW-1:0] Sentinel = ValW'(1000000000);
  localparam logic [PosW:0] DepthPos = (PosW + 1)'(Depth);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [PosW-1:0] SizeReset = PosW'(1024);

  localparam logic FuncUpdate = 1'b0;
  localparam logic FuncQuery = 1'b1;

  localparam logic [StatW-1:0] StatQuery = 2'd0;
  localparam logic [StatW-1:0] StatUpdDone = 2'd1;
  localparam logic [StatW-1:0] StatUpdIgnored = 2'd2;

endpackage

// ===== src/prefix_minimum_tree.sv =====
// Prefix-minimum binary indexed tree over positions 1 to min(size_in_use, 1024).
// Input channel (in_valid_i/in_ready_o) carries func_i, position_i and
// value_i: an update lowers every node covering position_i to value_i, a
// query returns the minimum over positions 1 to position_i. Each input
// transaction yields exactly one output transaction (out_valid_o/
// out_ready_i) with prefix_min_o, found_o and status_o.
// The nodes live in one synchronous RAM with a registered read port; the
// walk reads, compares and writes back one node per cycle, issuing the
// next read in the same cycle as the write of the current node.
// The walk visits k nodes, where k is at most log2(1024) + 1 = 11; an
// ignored update or an empty query skips the walk. One item walks at a
// time, so a new transaction is accepted only once the previous result
// has moved to the output register.
// A finished result sits in an output register, so the next transaction is
// accepted while the receiver stalls; a walk that ends while that register
// is still full holds its result until the register drains.
// Reset: rst_ni clears control and starts a clearing pass that
// sets every node to the sentinel; no input is accepted during that pass.
// size_in_use resets to 1024 and is written through cfg_we_i/cfg_wdata_i.
module prefix_minimum_tree
  import pmt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [PosW-1:0]  cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             func_i,
  input  logic [PosW-1:0]  position_i,
  input  logic [ValW-1:0]  value_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ValW-1:0]  prefix_min_o,
  output logic             found_o,
  output logic [StatW-1:0] status_o
);

  localparam logic [1:0] SClear = 2'd0;
  localparam logic [1:0] SIdle  = 2'd1;
  localparam logic [1:0] SWalk  = 2'd2;
  localparam logic [1:0] SFin   = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic [PosW-1:0]  size_q;
  logic             func_q, func_d;
  logic [PosW:0]    pos_q, pos_d;
  logic [ValW-1:0]  val_q, val_d;
  logic [ValW-1:0]  best_q, best_d;
  logic [ValW-1:0]  res_min_q, res_min_d;
  logic             res_found_q, res_found_d;
  logic [StatW-1:0] res_stat_q, res_stat_d;
  logic             out_valid_q, out_valid_d;
  logic [ValW-1:0]  out_min_q;
  logic             out_found_q;
  logic [StatW-1:0] out_stat_q;
  logic             out_load;

  logic [ValW-1:0]  mem [Depth];
  logic [ValW-1:0]  rd_data_q;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [ValW-1:0]  wr_data;

  logic [PosW:0]    n_eff;
  logic [PosW:0]    in_pos;
  logic [PosW:0]    q_pos;
  logic [PosW:0]    in_pos_m1;
  logic [PosW:0]    low_bit;
  logic [PosW:0]    nxt;
  logic [PosW:0]    nxt_m1;
  logic [ValW-1:0]  cand_min;

  assign n_eff = ({1'b0, size_q} < DepthPos) ? {1'b0, size_q} : DepthPos;
  assign in_pos = {1'b0, position_i};
  assign q_pos = (in_pos > n_eff) ? n_eff : in_pos;
  assign low_bit = pos_q & (~pos_q + 1'b1);
  assign cand_min = (rd_data_q < best_q) ? rd_data_q : best_q;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    func_d      = func_q;
    pos_d       = pos_q;
    val_d       = val_q;
    best_d      = best_q;
    res_min_d   = res_min_q;
    res_found_d = res_found_q;
    res_stat_d  = res_stat_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_load    = 1'b0;
    in_ready_o  = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = '0;
    in_pos_m1   = '0;
    nxt         = '0;
    nxt_m1      = '0;

    case (state_q)
      SClear: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = Sentinel;
        clr_d   = clr_q + 1'b1;
        if (clr_q == LastAddr) begin
          state_d = SIdle;
        end
      end
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          func_d = func_i;
          val_d  = value_i;
          best_d = Sentinel;
          if (func_i == FuncUpdate) begin
            in_pos_m1 = in_pos - 1'b1;
            if (in_pos == '0 || in_pos > n_eff) begin
              res_min_d   = '0;
              res_found_d = 1'b0;
              res_stat_d  = StatUpdIgnored;
              state_d     = SFin;
            end else begin
              rd_en   = 1'b1;
              rd_addr = in_pos_m1[AddrW-1:0];
              pos_d   = in_pos;
              state_d = SWalk;
            end
          end else begin
            in_pos_m1 = q_pos - 1'b1;
            if (q_pos == '0) begin
              res_min_d   = Sentinel;
              res_found_d = 1'b0;
              res_stat_d  = StatQuery;
              state_d     = SFin;
            end else begin
              rd_en   = 1'b1;
              rd_addr = in_pos_m1[AddrW-1:0];
              pos_d   = q_pos;
              state_d = SWalk;
            end
          end
        end
      end
      SWalk: begin
        if (func_q == FuncUpdate) begin
          nxt_m1  = pos_q - 1'b1;
          wr_en   = val_q < rd_data_q;
          wr_addr = nxt_m1[AddrW-1:0];
          wr_data = val_q;
          nxt     = pos_q + low_bit;
          if (nxt <= n_eff) begin
            nxt_m1  = nxt - 1'b1;
            rd_en   = 1'b1;
            rd_addr = nxt_m1[AddrW-1:0];
            pos_d   = nxt;
          end else begin
            res_min_d   = '0;
            res_found_d = 1'b0;
            res_stat_d  = StatUpdDone;
            state_d     = SFin;
          end
        end else begin
          best_d = cand_min;
          nxt    = pos_q - low_bit;
          if (nxt != '0) begin
            nxt_m1  = nxt - 1'b1;
            rd_en   = 1'b1;
            rd_addr = nxt_m1[AddrW-1:0];
            pos_d   = nxt;
          end else begin
            res_min_d   = cand_min;
            res_found_d = cand_min < Sentinel;
            res_stat_d  = StatQuery;
            state_d     = SFin;
          end
        end
      end
      SFin: begin
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClear;
      clr_q       <= '0;
      size_q      <= SizeReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    func_q      <= func_d;
    pos_q       <= pos_d;
    val_q       <= val_d;
    best_q      <= best_d;
    res_min_q   <= res_min_d;
    res_found_q <= res_found_d;
    res_stat_q  <= res_stat_d;
    if (out_load) begin
      out_min_q   <= res_min_q;
      out_found_q <= res_found_q;
      out_stat_q  <= res_stat_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign prefix_min_o = out_min_q;
  assign found_o      = out_found_q;
  assign status_o     = out_stat_q;

endmodule

// ===== test/tb_prefix_minimum_tree.sv =====
module tb_prefix_minimum_tree;
  import pmt_pkg::*;

  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned NumPhases = 10;
  localparam logic [ValW-1:0] ValAllOnes = '1;
  localparam logic [PosW-1:0] PosAllOnes = '1;

  typedef struct packed {
    logic [ValW-1:0]  prefix_min;
    logic             found;
    logic [StatW-1:0] status;
  } answer_t;

  class min_tree_mirror;
    logic [ValW-1:0] nodes [Depth];
    logic [PosW-1:0] size_cfg;
    answer_t         answers_due [$];
    int              errors;

    function new();
      foreach (nodes[i]) nodes[i] = Sentinel;
      size_cfg = SizeReset;
      errors = 0;
    endfunction

    function void note_transaction(logic func, logic [PosW-1:0] pos, logic [ValW-1:0] val);
      int unsigned     n;
      int unsigned     p;
      logic [ValW-1:0] best;
      answer_t         ans;
      n = (32'(size_cfg) < Depth) ? 32'(size_cfg) : Depth;
      p = 32'(pos);
      ans = '0;
      if (func == FuncUpdate) begin
        if (p == 0 || p > n) begin
          ans.status = StatUpdIgnored;
        end else begin
          while (p != 0 && p <= n) begin
            if (val < nodes[p-1]) nodes[p-1] = val;
            p += p & (~p + 1);
          end
          ans.status = StatUpdDone;
        end
      end else begin
        best = Sentinel;
        if (p > n) p = n;
        while (p != 0) begin
          if (nodes[p-1] < best) best = nodes[p-1];
          p -= p & (~p + 1);
        end
        ans.prefix_min = best;
        ans.found = (best < Sentinel);
        ans.status = StatQuery;
      end
      answers_due.push_back(ans);
    endfunction

    function void check_answer(logic [ValW-1:0] pmin, logic fnd, logic [StatW-1:0] stat);
      answer_t want;
      if (answers_due.size() == 0) begin
        $error("unexpected result: prefix_min %0d found %0d status %0d", pmin, fnd, stat);
        errors++;
        return;
      end
      want = answers_due.pop_front();
      if (pmin !== want.prefix_min) begin
        $error("prefix_min mismatch: expected %0d, actual %0d", want.prefix_min, pmin);
        errors++;
      end
      if (fnd !== want.found) begin
        $error("found mismatch: expected %0d, actual %0d", want.found, fnd);
        errors++;
      end
      if (stat !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, stat);
        errors++;
      end
    endfunction

    function int pending();
      return answers_due.size();
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [PosW-1:0]  cfg_wdata_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic             func_i = FuncUpdate;
  logic [PosW-1:0]  position_i = '0;
  logic [ValW-1:0]  value_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [ValW-1:0]  prefix_min_o;
  logic             found_o;
  logic [StatW-1:0] status_o;

  min_tree_mirror mirror;
  int             burst_left = 0;
  int unsigned    idle_cycles = 0;

  prefix_minimum_tree i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .position_i  (position_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .prefix_min_o(prefix_min_o),
    .found_o     (found_o),
    .status_o    (status_o)
  );

  initial begin
    forever begin
      #5 clk_i = ~clk_i;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      mirror.check_answer(prefix_min_o, found_o, status_o);
    end
  end

  initial begin
    int mode;
    int len;
    forever begin
      mode = $urandom_range(0, 3);
      len = $urandom_range(10, 60);
      repeat (len) begin
        @(posedge clk_i);
        case (mode)
          0: begin
            out_ready_i <= 1'b1;
          end
          1: begin
            out_ready_i <= 1'($urandom_range(0, 1));
          end
          2: begin
            out_ready_i <= ($urandom_range(0, 3) != 0);
          end
          default: begin
            out_ready_i <= 1'b0;
          end
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("tb_prefix_minimum_tree: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic drive_item(logic func, logic [PosW-1:0] pos, logic [ValW-1:0] val);
    in_valid_i <= 1'b1;
    func_i <= func;
    position_i <= pos;
    value_i <= val;
    do @(posedge clk_i); while (!in_ready_o);
    mirror.note_transaction(func, pos, val);
  endtask

  task automatic send(logic func, logic [PosW-1:0] pos, logic [ValW-1:0] val);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 :
            ($urandom_range(0, 9) == 0) ? 25 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    drive_item(func, pos, val);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (mirror.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_size(logic [PosW-1:0] size);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= size;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mirror.size_cfg = size;
  endtask

  initial begin
    int unsigned     phase_size [NumPhases];
    int unsigned     phase_items [NumPhases];
    int unsigned     n_eff;
    int unsigned     ceiling;
    int unsigned     roll;
    logic            func;
    logic [PosW-1:0] pos;
    logic [ValW-1:0] val;

    phase_size = '{1, 0, 2, 2047, 37, 1024, 8, 1023, 0, 512};
    phase_items = '{40, 20, 40, 100, 100, 120, 60, 120, 100, 100};
    mirror = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    send(FuncQuery, 0, ValW'($urandom()));
    send(FuncQuery, 1024, 0);
    send(FuncQuery, PosAllOnes, ValAllOnes);
    send(FuncUpdate, 0, 5);
    send(FuncUpdate, 1025, 5);
    send(FuncUpdate, PosAllOnes, 5);
    send(FuncUpdate, 3, ValAllOnes);
    send(FuncUpdate, 3, Sentinel);
    send(FuncQuery, 3, 0);
    send(FuncUpdate, 1024, 0);
    send(FuncQuery, 1023, 0);
    send(FuncQuery, 1024, 0);
    send(FuncUpdate, 1, 999999999);
    send(FuncQuery, 1, 0);
    send(FuncUpdate, 6, 1234);
    send(FuncQuery, 5, 0);
    send(FuncQuery, 7, 0);
    send(FuncUpdate, 6, 2000);
    send(FuncQuery, 6, 0);
    send(FuncUpdate, 1023, 536870912);
    send(FuncQuery, PosAllOnes, 0);

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      if (ph == 8) phase_size[ph] = $urandom_range(1, 1024);
      write_size(PosW'(phase_size[ph]));
      n_eff = (phase_size[ph] < Depth) ? phase_size[ph] : Depth;
      ceiling = 999999999 >> ph;
      for (int k = 0; k < phase_items[ph]; k++) begin
        func = 1'($urandom_range(0, 1));
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
          pos = 0;
        end else if (roll < 15 || n_eff == 0) begin
          pos = PosW'($urandom_range(n_eff + 1, 2047));
        end else begin
          pos = PosW'($urandom_range(1, n_eff));
        end
        if ($urandom_range(0, 99) < 20) begin
          val = ValW'($urandom());
        end else begin
          val = ValW'($urandom_range(0, ceiling));
        end
        send(func, pos, val);
      end
    end

    drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (mirror.errors == 0 && mirror.pending() == 0) begin
      $display("tb_prefix_minimum_tree: PASS");
    end else begin
      $display("tb_prefix_minimum_tree: FAIL");
    end
    $finish;
  end

endmodule
